// File: rtl/core/audio_startup_envelope_limiter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the start-up envelope limiter
// Concurrent checks that drop away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AUDIO_STARTUP_ENVELOPE_LIMITER_DEFINES_SVH
`define AUDIO_STARTUP_ENVELOPE_LIMITER_DEFINES_SVH

`ifndef SYNTHESIS

// Checked at every rising edge, held off while reset is high.
`define ASEL_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASEL_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASEL_ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASEL_ASSERT(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/core/asel_pkg.sv
// ----------------------------------------------------------------------------
// asel_pkg
// Types and constants shared by the start-up envelope limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asel_pkg;

   localparam int SampleWidth = 16;
   localparam int StepWidth   = 15;
   localparam int ExpireWidth = 24;
   localparam int CountWidth  = 25;
   localparam int CsrIdxWidth = 2;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_EDGE_STEP     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_EDGE_CEILING  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_EXPIRE_FRAMES = 2'd2;

   // input item function codes
   localparam logic FUNC_FRAME      = 1'b0;
   localparam logic FUNC_REACTIVATE = 1'b1;

   typedef struct packed {
      logic                          func;
      logic                          stereo;
      logic signed [SampleWidth-1:0] left_in;
      logic signed [SampleWidth-1:0] right_in;
   } asel_req_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] left_out;
      logic signed [SampleWidth-1:0] right_out;
      logic                          pressed;
      logic                          still_active;
   } asel_rsp_type;

   // clamp unit result
   typedef struct packed {
      logic signed [SampleWidth-1:0] sample;
      logic                          pressed;
   } asel_clamp_type;

endpackage

// File: rtl/core/asel_clamp.sv
// ----------------------------------------------------------------------------
// asel_clamp
// Clamps one sample to +/- lip when its magnitude exceeds the edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asel_clamp (
   input  logic signed [asel_pkg::SampleWidth-1:0] sample_in,
   input  logic        [asel_pkg::SampleWidth-1:0] edge_lvl,
   input  logic        [asel_pkg::SampleWidth:0]   lip,
   output asel_pkg::asel_clamp_type                result
);
   import asel_pkg::*;

   // two guard bits: magnitude of -32768 and lips up to 17 bits
   logic signed [SampleWidth+1:0] s_ext;
   logic signed [SampleWidth+1:0] mag;
   logic signed [SampleWidth+1:0] edge_ext;
   logic signed [SampleWidth+1:0] lip_pos;
   logic signed [SampleWidth+1:0] lip_neg;

   assign s_ext    = {{2{sample_in[SampleWidth-1]}}, sample_in};
   assign mag      = sample_in[SampleWidth-1] ? -s_ext : s_ext;
   assign edge_ext = {2'b00, edge_lvl};
   assign lip_pos  = {1'b0, lip};
   assign lip_neg  = -lip_pos;

   always_comb begin
      result.pressed = (mag > edge_ext);
      result.sample  = sample_in;
      if (result.pressed) begin
         // lip is at most 32767 whenever a bound is hit, so the part-select is exact
         if (s_ext > lip_pos) begin
            result.sample = lip_pos[SampleWidth-1:0];
         end else if (s_ext < lip_neg) begin
            result.sample = lip_neg[SampleWidth-1:0];
         end
      end
   end

endmodule

// File: rtl/core/audio_startup_envelope_limiter.sv
// ----------------------------------------------------------------------------
// audio_startup_envelope_limiter
// Start-up envelope limiter: clamps early samples to a growing edge.
// ----------------------------------------------------------------------------
// One item (an audio frame or a reactivate command) is accepted per clock and
// its result is registered in rsp, or in skid on a stall; the sustained rate is
// one item per cycle for as long as the result side keeps taking. The whole
// frame is processed in the accept cycle (two clamp units, one edge add, one
// count increment and compare) and lands in a two-entry output buffer, so
// req_stall rises only when both entries hold results that have not been
// taken. Registers on the csr port may be written at any time the block is
// idle; csr_ready is always high and unknown indexes are dropped.
`timescale 1ns / 1ps

`include "audio_startup_envelope_limiter_defines.svh"

module audio_startup_envelope_limiter (
   input  logic                              clock,
   input  logic                              reset,
   // item input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  asel_pkg::asel_req_type            req_data,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output asel_pkg::asel_rsp_type            rsp_data,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [asel_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [asel_pkg::ExpireWidth-1:0]  csr_data
);
   import asel_pkg::*;

   // ---------------------------------------------------------------- config
   logic [StepWidth-1:0]   step_ff,    step_in;
   logic [StepWidth-1:0]   ceiling_ff, ceiling_in;
   logic [ExpireWidth-1:0] expire_ff,  expire_in;
   logic                   csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      step_in    = step_ff;
      ceiling_in = ceiling_ff;
      expire_in  = expire_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_EDGE_STEP:     step_in    = csr_data[StepWidth-1:0];
            CSR_EDGE_CEILING:  ceiling_in = csr_data[StepWidth-1:0];
            CSR_EXPIRE_FRAMES: expire_in  = csr_data;
            default: ;  // no such register
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= StepWidth'(1);
         ceiling_ff <= {StepWidth{1'b1}};
         expire_ff  <= {ExpireWidth{1'b1}};
      end else begin
         step_ff    <= step_in;
         ceiling_ff <= ceiling_in;
         expire_ff  <= expire_in;
      end
   end

   // ---------------------------------------------------------------- envelope state
   logic [SampleWidth-1:0] edge_ff,   edge_in;
   logic [CountWidth-1:0]  count_ff,  count_in;
   logic                   active_ff, active_in;

   logic                   req_accept;
   logic                   rsp_accept;
   logic                   is_reactivate;
   logic                   started;
   logic signed [SampleWidth-1:0] right_gated;
   logic [SampleWidth:0]   lip;
   logic [SampleWidth-1:0] edge_grown;
   logic [CountWidth-1:0]  count_next;
   asel_clamp_type         clamp_l;
   asel_clamp_type         clamp_r;
   asel_rsp_type           result;

   assign req_accept    = req_valid & ~req_stall;
   assign rsp_accept    = rsp_valid & ~rsp_stall;
   assign is_reactivate = (req_data.func == FUNC_REACTIVATE);

   // mono frames carry a zero right sample, which never presses
   assign right_gated = req_data.stereo ? req_data.right_in : '0;

   // waiting for start: first nonzero left sample opens the envelope
   assign started = active_ff & ~((req_data.left_in == '0) && (count_ff == '0));

   assign lip        = {1'b0, edge_ff} + {2'b00, step_ff};
   assign edge_grown = lip[SampleWidth-1:0];
   assign count_next = count_ff + CountWidth'(1);

   asel_clamp u_clamp_l (
      .sample_in (req_data.left_in),
      .edge_lvl  (edge_ff),
      .lip       (lip),
      .result    (clamp_l)
   );

   asel_clamp u_clamp_r (
      .sample_in (right_gated),
      .edge_lvl  (edge_ff),
      .lip       (lip),
      .result    (clamp_r)
   );

   always_comb begin
      edge_in   = edge_ff;
      count_in  = count_ff;
      active_in = active_ff;
      result.left_out     = req_data.left_in;
      result.right_out    = right_gated;
      result.pressed      = 1'b0;
      result.still_active = active_ff;
      priority if (is_reactivate) begin
         edge_in   = '0;
         count_in  = '0;
         active_in = 1'b1;
         result.left_out     = '0;
         result.right_out    = '0;
         result.still_active = 1'b1;
      end else if (started) begin
         result.left_out  = clamp_l.sample;
         result.right_out = clamp_r.sample;
         result.pressed   = clamp_l.pressed | clamp_r.pressed;
         if (result.pressed) begin
            edge_in = edge_grown;
         end
         count_in = count_next;
         // expiry or ceiling ends the envelope
         if ((count_next > {1'b0, expire_ff}) || (edge_in >= {1'b0, ceiling_ff})) begin
            active_in = 1'b0;
         end
         result.still_active = active_in;
      end else begin
         // inactive or still waiting: frame passes, state holds
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff   <= '0;
         count_ff  <= '0;
         active_ff <= 1'b1;
      end else if (req_accept) begin
         edge_ff   <= edge_in;
         count_ff  <= count_in;
         active_ff <= active_in;
      end
   end

   // ---------------------------------------------------------------- output buffer
   // rsp holds the head result; skid catches one more while rsp is stalled.
   logic         rsp_valid_ff,  rsp_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   asel_rsp_type rsp_data_ff,   rsp_data_in;
   asel_rsp_type skid_data_ff,  skid_data_in;

   assign req_stall = skid_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         // no transfer in: just drain skid into rsp
         if (rsp_accept) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff || rsp_accept) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (rsp_accept) begin
         rsp_valid_in = 1'b0;
      end else begin
         // nothing moves
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // ---------------------------------------------------------------- checks
   `ASEL_ASSERT(a_skid_behind_rsp, clock, skid_valid_ff |-> rsp_valid_ff, "skid full, rsp empty")
   `ASEL_ASSERT_RST(a_accept_gives_rsp, clock, reset, req_accept |=> rsp_valid_ff, "transfer lost")
   `ASEL_ASSERT_RST(a_reactivate_clears, clock, reset,
      (req_accept && is_reactivate) |=> (active_ff && edge_ff == '0 && count_ff == '0),
      "reactivate did not clear envelope")
   `ASEL_ASSERT_RST(a_idle_edge_holds, clock, reset,
      (!active_ff && !(req_accept && is_reactivate)) |=> $stable(edge_ff) && !active_ff,
      "inactive envelope changed")

endmodule
